// ----- design/slcd_pkg.sv -----
// Shared types, codes and glyph tables for the segment LCD scan driver.
`default_nettype none

package slcd_pkg;

  localparam int SEG_PINS    = 6;
  localparam int COMMONS     = 4;
  localparam int WORD_W      = 4;
  localparam int DIGIT_WORDS = 6;

  typedef enum logic [2:0] {
    KIND_REFRESH    = 3'd0,
    KIND_MASKED     = 3'd1,
    KIND_DIGITS     = 3'd2,
    KIND_DIGITS_ALT = 3'd3,
    KIND_FILL       = 3'd4
  } kind_t;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] phase;
    logic [2:0] seg_index;
    logic [7:0] bit_mask;
    logic [7:0] write_value;
    logic [3:0] digit_hundreds;
    logic [3:0] digit_tens;
    logic [3:0] digit_ones;
  } item_t;

  typedef struct packed {
    logic [COMMONS-1:0]  common_level;
    logic [COMMONS-1:0]  common_bias_enable;
    logic [SEG_PINS-1:0] segment_level;
  } frame_t;

  function automatic word_t glyph_lo(input logic [3:0] code);
    word_t w;
    case (code)
      4'd0:    w = 4'hA;
      4'd2:    w = 4'hC;
      4'd3:    w = 4'h4;
      4'd4:    w = 4'h6;
      4'd5:    w = 4'h6;
      4'd6:    w = 4'hE;
      4'd8:    w = 4'hE;
      4'd9:    w = 4'h6;
      4'd11:   w = 4'h4;
      default: w = 4'h0;
    endcase
    return w;
  endfunction

  function automatic word_t glyph_hi(input logic [3:0] code);
    word_t w;
    case (code)
      4'd0:    w = 4'hF;
      4'd1:    w = 4'h6;
      4'd2:    w = 4'hB;
      4'd3:    w = 4'hF;
      4'd4:    w = 4'h6;
      4'd5:    w = 4'hD;
      4'd6:    w = 4'hD;
      4'd7:    w = 4'h7;
      4'd8:    w = 4'hF;
      4'd9:    w = 4'hF;
      default: w = 4'h0;
    endcase
    return w;
  endfunction

  function automatic word_t glyph_lo_alt(input logic [3:0] code);
    word_t w;
    case (code)
      4'd0:    w = 4'hB;
      4'd1:    w = 4'h1;
      4'd2:    w = 4'hD;
      4'd3:    w = 4'h5;
      4'd4:    w = 4'h7;
      4'd5:    w = 4'h7;
      4'd6:    w = 4'hF;
      4'd7:    w = 4'h1;
      4'd8:    w = 4'hF;
      4'd9:    w = 4'h7;
      4'd10:   w = 4'h1;
      4'd11:   w = 4'h5;
      default: w = 4'h0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- design/slcd_cmd_if.sv -----
// Command channel: refresh and store write items.
`default_nettype none

interface slcd_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [2:0] phase;
  logic [2:0] seg_index;
  logic [7:0] bit_mask;
  logic [7:0] write_value;
  logic [3:0] digit_hundreds;
  logic [3:0] digit_tens;
  logic [3:0] digit_ones;

  modport source (
    output valid, kind, phase, seg_index, bit_mask, write_value,
           digit_hundreds, digit_tens, digit_ones,
    input  ready
  );

  modport sink (
    input  valid, kind, phase, seg_index, bit_mask, write_value,
           digit_hundreds, digit_tens, digit_ones,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/slcd_frame_if.sv -----
// Frame channel: common and segment pin levels for one refresh phase.
`default_nettype none

interface slcd_frame_if;
  logic       valid;
  logic       ready;
  logic [3:0] common_level;
  logic [3:0] common_bias_enable;
  logic [5:0] segment_level;

  modport source (
    output valid, common_level, common_bias_enable, segment_level,
    input  ready
  );

  modport sink (
    input  valid, common_level, common_bias_enable, segment_level,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/slcd_store.sv -----
// Segment store: masked, digit and fill writes into the word registers.
`default_nettype none

module slcd_store
  import slcd_pkg::*;
#(
  parameter int NUM_SEGMENTS = 6
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_en,
  input  wire item_t item,
  output word_t      words [NUM_SEGMENTS]
);

  word_t digit_words [DIGIT_WORDS];

  always_comb begin
    digit_words[0] = glyph_lo(item.digit_hundreds);
    digit_words[1] = glyph_hi(item.digit_hundreds);
    digit_words[2] = (item.kind == KIND_DIGITS_ALT) ? glyph_lo_alt(item.digit_tens)
                                                    : glyph_lo(item.digit_tens);
    digit_words[3] = glyph_hi(item.digit_tens);
    digit_words[4] = (item.kind == KIND_DIGITS_ALT) ? glyph_lo_alt(item.digit_ones)
                                                    : glyph_lo(item.digit_ones);
    digit_words[5] = glyph_hi(item.digit_ones);
  end

  for (genvar j = 0; j < NUM_SEGMENTS; j++) begin : g_word
    logic  idx_hit;
    word_t digit_val;
    logic  digit_ok;
    word_t word_next;

    // seg_index is three bits wide, so words above seven are never addressed
    if (j < 8) begin : g_idx
      assign idx_hit = (item.seg_index == 3'(j));
    end else begin : g_noidx
      assign idx_hit = 1'b0;
    end

    if (j < DIGIT_WORDS) begin : g_dig
      assign digit_val = digit_words[j];
      assign digit_ok  = 1'b1;
    end else begin : g_nodig
      assign digit_val = '0;
      assign digit_ok  = 1'b0;
    end

    always_comb begin
      word_next = words[j];
      case (item.kind)
        KIND_MASKED: begin
          if (idx_hit) begin
            word_next = (words[j] & ~item.bit_mask[WORD_W-1:0]) |
                        (item.write_value[WORD_W-1:0] & item.bit_mask[WORD_W-1:0]);
          end
        end
        KIND_DIGITS, KIND_DIGITS_ALT: begin
          if (digit_ok) begin
            word_next = digit_val;
          end
        end
        KIND_FILL: word_next = item.write_value[WORD_W-1:0];
        default:   word_next = words[j];
      endcase
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        words[j] <= '0;
      end else if (wr_en) begin
        words[j] <= word_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/slcd_refresh.sv -----
// Refresh decode: common levels, bias enables and segment levels for a phase.
`default_nettype none

module slcd_refresh
  import slcd_pkg::*;
#(
  parameter int NUM_SEGMENTS = 6
) (
  input  wire word_t      words [NUM_SEGMENTS],
  input  wire logic [2:0] phase,
  output frame_t          frame
);

  logic [1:0]          sel;
  logic [COMMONS-1:0]  onehot;
  logic [SEG_PINS-1:0] raw;

  assign sel    = phase[1:0];
  assign onehot = COMMONS'(1) << sel;

  // pins with no store word read as off
  for (genvar j = 0; j < SEG_PINS; j++) begin : g_pin
    if (j < NUM_SEGMENTS) begin : g_word
      assign raw[j] = words[j][sel];
    end else begin : g_none
      assign raw[j] = 1'b0;
    end
  end

  // upper half of the cycle: all commons high, segments inverted
  assign frame.common_level       = phase[2] ? {COMMONS{1'b1}} : ~onehot;
  assign frame.common_bias_enable = ~onehot;
  assign frame.segment_level      = raw ^ {SEG_PINS{phase[2]}};

endmodule

`default_nettype wire

// ----- design/segment_lcd_scan_driver.sv -----
// A refresh transaction's frame reaches the outputs through the input register and then the frame register.
// Throughput: one transaction per cycle; while a stalled sink holds the frame register,
// a refresh waits in the input register and the input waits behind it.
// Each transaction passes an input register, then the store/decode logic.
// Reset (synchronous, active high) empties both registers and clears the store.
`default_nettype none

module segment_lcd_scan_driver
  import slcd_pkg::*;
#(
  parameter int NUM_SEGMENTS = 6
) (
  input  wire logic    clk,
  input  wire logic    rst,
  slcd_cmd_if.sink     cmd,
  slcd_frame_if.source frame
);

  logic   stage_valid;
  item_t  stage;
  logic   stage_refresh;
  logic   frame_free;
  logic   advance;
  word_t  words [NUM_SEGMENTS];
  frame_t frame_next;
  frame_t frame_reg;
  logic   frame_valid;

  assign stage_refresh = (stage.kind == KIND_REFRESH);
  assign frame_free    = !frame_valid || frame.ready;
  assign advance       = stage_valid && (!stage_refresh || frame_free);
  assign cmd.ready     = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.ready) begin
      stage_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      stage.kind           <= cmd.kind;
      stage.phase          <= cmd.phase;
      stage.seg_index      <= cmd.seg_index;
      stage.bit_mask       <= cmd.bit_mask;
      stage.write_value    <= cmd.write_value;
      stage.digit_hundreds <= cmd.digit_hundreds;
      stage.digit_tens     <= cmd.digit_tens;
      stage.digit_ones     <= cmd.digit_ones;
    end
  end

  slcd_store #(
    .NUM_SEGMENTS(NUM_SEGMENTS)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .wr_en(advance),
    .item (stage),
    .words(words)
  );

  slcd_refresh #(
    .NUM_SEGMENTS(NUM_SEGMENTS)
  ) u_refresh (
    .words(words),
    .phase(stage.phase),
    .frame(frame_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame_free) begin
      frame_valid <= stage_valid && stage_refresh;
    end
  end

  // hold the frame while the sink stalls
  always_ff @(posedge clk) begin
    if (frame_free && stage_valid && stage_refresh) begin
      frame_reg <= frame_next;
    end
  end

  assign frame.valid              = frame_valid;
  assign frame.common_level       = frame_reg.common_level;
  assign frame.common_bias_enable = frame_reg.common_bias_enable;
  assign frame.segment_level      = frame_reg.segment_level;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the segment LCD scan driver: stimulus, store predictor, checker.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import slcd_pkg::*;

  localparam int NUM_WORDS     = 6;
  localparam int MAX_GAP       = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 700;
  localparam int CYCLE_LIMIT   = 200000;

  // Unused command kinds, which the block must ignore.
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // Seven-segment tables, one nibble per digit code, code 0 in the low nibble.
  localparam logic [63:0] LO_GLYPHS  = 64'h0000_406E_0E66_4C0A;
  localparam logic [63:0] HI_GLYPHS  = 64'h0000_00FF_7DD6_FB6F;
  localparam logic [63:0] ALT_GLYPHS = 64'h0000_517F_1F77_5D1B;

  logic clk = 1'b0;
  logic rst;

  slcd_cmd_if   cmd ();
  slcd_frame_if frame ();

  segment_lcd_scan_driver #(.NUM_SEGMENTS(NUM_WORDS)) dut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .frame (frame)
  );

  always #5ns clk = ~clk;

  word_t  glass_store [NUM_WORDS];
  frame_t frames_due [$];
  int     mismatches  = 0;
  int     cycle_count = 0;
  bit     send_idle   = 1'b1;
  bit     recv_idle   = 1'b1;

  function automatic word_t glyph_nibble(input logic [63:0] glyphs, input logic [3:0] code);
    return glyphs[{code, 2'b00} +: 4];
  endfunction

  // Update the predicted store, or queue the frame a refresh must produce.
  function automatic void apply_command(input item_t txn);
    frame_t      f;
    logic [3:0]  onehot;
    logic [1:0]  sel;
    logic [63:0] low_glyphs;
    case (txn.kind)
      KIND_REFRESH: begin
        sel = txn.phase[1:0];
        onehot = 4'b0001 << sel;
        for (int j = 0; j < SEG_PINS; j++) begin
          f.segment_level[j] = glass_store[j][sel] ^ txn.phase[2];
        end
        f.common_bias_enable = ~onehot;
        f.common_level = txn.phase[2] ? 4'hF : ~onehot;
        frames_due.push_back(f);
      end
      KIND_MASKED: begin
        if (txn.seg_index < NUM_WORDS) begin
          glass_store[txn.seg_index] = (glass_store[txn.seg_index] & ~txn.bit_mask[3:0]) |
                                       (txn.write_value[3:0] & txn.bit_mask[3:0]);
        end
      end
      KIND_DIGITS, KIND_DIGITS_ALT: begin
        low_glyphs = (txn.kind == KIND_DIGITS_ALT) ? ALT_GLYPHS : LO_GLYPHS;
        glass_store[0] = glyph_nibble(LO_GLYPHS, txn.digit_hundreds);
        glass_store[1] = glyph_nibble(HI_GLYPHS, txn.digit_hundreds);
        glass_store[2] = glyph_nibble(low_glyphs, txn.digit_tens);
        glass_store[3] = glyph_nibble(HI_GLYPHS, txn.digit_tens);
        glass_store[4] = glyph_nibble(low_glyphs, txn.digit_ones);
        glass_store[5] = glyph_nibble(HI_GLYPHS, txn.digit_ones);
      end
      KIND_FILL: begin
        for (int j = 0; j < NUM_WORDS; j++) glass_store[j] = txn.write_value[3:0];
      end
      default: ;
    endcase
  endfunction

  function automatic item_t random_fields();
    item_t r;
    r.kind           = 3'($urandom_range(0, 7));
    r.phase          = 3'($urandom_range(0, 7));
    r.seg_index      = 3'($urandom_range(0, 7));
    r.bit_mask       = 8'($urandom_range(0, 255));
    r.write_value    = 8'($urandom_range(0, 255));
    r.digit_hundreds = 4'($urandom_range(0, 15));
    r.digit_tens     = 4'($urandom_range(0, 15));
    r.digit_ones     = 4'($urandom_range(0, 15));
    return r;
  endfunction

  function automatic item_t random_command();
    item_t r;
    int    pick;
    r = random_fields();
    pick = $urandom_range(0, 99);
    if (pick < 40)      r.kind = KIND_REFRESH;
    else if (pick < 60) r.kind = KIND_MASKED;
    else if (pick < 75) r.kind = KIND_DIGITS;
    else if (pick < 85) r.kind = KIND_DIGITS_ALT;
    else if (pick < 93) r.kind = KIND_FILL;
    else                r.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    return r;
  endfunction

  // Drive valid low through the gap, then present the transaction until it is taken.
  task automatic send_command(input item_t txn);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid          <= 1'b1;
    cmd.kind           <= txn.kind;
    cmd.phase          <= txn.phase;
    cmd.seg_index      <= txn.seg_index;
    cmd.bit_mask       <= txn.bit_mask;
    cmd.write_value    <= txn.write_value;
    cmd.digit_hundreds <= txn.digit_hundreds;
    cmd.digit_tens     <= txn.digit_tens;
    cmd.digit_ones     <= txn.digit_ones;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    apply_command(txn);
  endtask

  task automatic drain_frames();
    cmd.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic refresh(input logic [2:0] phase);
    item_t txn;
    txn = random_fields();
    txn.kind = KIND_REFRESH;
    txn.phase = phase;
    send_command(txn);
  endtask

  task automatic masked_write(input logic [2:0] idx, input logic [7:0] mask,
                              input logic [7:0] value);
    item_t txn;
    txn = random_fields();
    txn.kind = KIND_MASKED;
    txn.seg_index = idx;
    txn.bit_mask = mask;
    txn.write_value = value;
    send_command(txn);
  endtask

  task automatic fill_store(input logic [7:0] value);
    item_t txn;
    txn = random_fields();
    txn.kind = KIND_FILL;
    txn.write_value = value;
    send_command(txn);
  endtask

  task automatic write_digits(input bit alt, input logic [3:0] h, input logic [3:0] t,
                              input logic [3:0] o);
    item_t txn;
    txn = random_fields();
    txn.kind = alt ? KIND_DIGITS_ALT : KIND_DIGITS;
    txn.digit_hundreds = h;
    txn.digit_tens = t;
    txn.digit_ones = o;
    send_command(txn);
  endtask

  task automatic test_blank_after_reset();
    refresh(3'd0);
    refresh(3'd7);
  endtask

  task automatic test_masked_write();
    masked_write(3'd0, 8'hFF, 8'hFF);
    masked_write(3'd5, 8'h0F, 8'hA5);
    // upper mask bits only: word must stay as is
    masked_write(3'd3, 8'hF0, 8'hFF);
    masked_write(3'd6, 8'hFF, 8'hFF);
    masked_write(3'd7, 8'hFF, 8'hFF);
    masked_write(3'd2, 8'h55, 8'h0A);
    refresh(3'd1);
    refresh(3'd6);
  endtask

  task automatic test_fill();
    fill_store(8'hFF);
    refresh(3'd2);
    refresh(3'd4);
    fill_store(8'h30);
    refresh(3'd3);
  endtask

  task automatic test_digits();
    write_digits(1'b0, 4'd0, 4'd9, 4'd12);
    refresh(3'd0);
    write_digits(1'b1, 4'd10, 4'd11, 4'd15);
    refresh(3'd5);
    write_digits(1'b1, 4'd8, 4'd7, 4'd13);
    refresh(3'd2);
  endtask

  task automatic test_unused_kinds();
    item_t txn;
    txn = random_fields();
    txn.kind = KIND_SPARE_LO;
    send_command(txn);
    txn = random_fields();
    txn.kind = KIND_SPARE_HI;
    send_command(txn);
    refresh(3'd3);
  endtask

  task automatic test_random_traffic();
    item_t txn;
    int    sent;
    for (int round = 0; round < 4; round++) begin
      send_idle = (round == 0) || (round == 2);
      recv_idle = (round == 0) || (round == 3);
      sent = 0;
      while (sent < RANDOM_ITEMS / 4) begin
        txn = random_command();
        send_command(txn);
        if (txn.kind <= KIND_FILL) sent++;
      end
      // let every frame come home before the next round
      drain_frames();
    end
  endtask

  // Frame side: stall at random, then hold ready until a frame is taken.
  initial begin
    int stall;
    forever begin
      stall = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        frame.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      frame.ready <= 1'b1;
      do @(posedge clk); while (!(frame.valid === 1'b1 && rst === 1'b0));
    end
  end

  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    if (rst === 1'b0 && frame.valid === 1'b1 && frame.ready === 1'b1) begin
      got = {frame.common_level, frame.common_bias_enable, frame.segment_level};
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected frame: com=%h bias=%h seg=%h",
                   got.common_level, got.common_bias_enable, got.segment_level);
      end else begin
        want = frames_due.pop_front();
        if (got.common_level !== want.common_level ||
            got.common_bias_enable !== want.common_bias_enable ||
            got.segment_level !== want.segment_level) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("frame mismatch: expected com=%h bias=%h seg=%h, got com=%h bias=%h seg=%h",
                     want.common_level, want.common_bias_enable, want.segment_level,
                     got.common_level, got.common_bias_enable, got.segment_level);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int j = 0; j < NUM_WORDS; j++) glass_store[j] = '0;
    rst                <= 1'b1;
    cmd.valid          <= 1'b0;
    cmd.kind           <= '0;
    cmd.phase          <= '0;
    cmd.seg_index      <= '0;
    cmd.bit_mask       <= '0;
    cmd.write_value    <= '0;
    cmd.digit_hundreds <= '0;
    cmd.digit_tens     <= '0;
    cmd.digit_ones     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_blank_after_reset();
    test_masked_write();
    test_fill();
    test_digits();
    test_unused_kinds();
    test_random_traffic();
    drain_frames();

    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
design/slcd_pkg.sv
design/slcd_cmd_if.sv
design/slcd_frame_if.sv
design/slcd_store.sv
design/slcd_refresh.sv
design/segment_lcd_scan_driver.sv
dv/testbench.sv
